>>> rtl/gpq_pkg.sv
// ----------------------------------------------------------------------------
// gpq_pkg
// Shared sizes, register indexes, the queue item type and the per-poll
// arithmetic of the gamepad input qualifier.
// ----------------------------------------------------------------------------
package gpq_pkg;

   localparam int PLAYERS      = 4;
   localparam int BUTTON_COUNT = 16;
   localparam int COUNT_WIDTH  = 16;

   localparam int PLAYER_IDX_W = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
   localparam int BTN_IDX_W    = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

   // stream and register port sizes
   localparam int REQ_DATA_W  = 104;
   localparam int REQ_USER_W  = 3;
   localparam int RSP_DATA_W  = 80;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLICK_DELTA       = 1'd1;

   localparam logic [7:0]  THRESHOLD_RESET = 8'd100;
   localparam logic [15:0] FLICK_RESET     = 16'd16384;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam count_type COUNT_MAX = '1;

   // one classified poll word, as it waits between front and back
   typedef struct packed {
      logic                    player_ok;
      logic [PLAYER_IDX_W-1:0] player_idx;
      logic                    poll_ok;
      logic [15:0]             buttons;
      logic [7:0]              left_trigger;
      logic [7:0]              right_trigger;
      logic signed [15:0]      left_x;
      logic signed [15:0]      left_y;
      logic signed [15:0]      right_x;
      logic signed [15:0]      right_y;
      logic                    button_ok;
      logic [BTN_IDX_W-1:0]    button_idx;
   } item_type;

   // clamp a hold counter to the 16-bit result field
   function automatic logic [15:0] report_count(input count_type cnt);
      logic [15:0] res;
      if ((cnt >> 16) != '0) begin
         res = 16'hFFFF;
      end else begin
         res = 16'(cnt);
      end
      return res;
   endfunction

   // rise of one trigger beyond the threshold since the last sample
   function automatic logic trigger_rise(input logic [7:0] cur, input logic [7:0] prv,
                                         input logic [7:0] thr);
      logic signed [9:0] diff;
      diff = signed'(10'(cur)) - signed'(10'(prv));
      return diff > signed'(10'(thr));
   endfunction

   // flick flags of one stick: bit0 right, bit1 left, bit2 up, bit3 down
   function automatic logic [3:0] flick_flags(input logic signed [15:0] px,
                                              input logic signed [15:0] nx,
                                              input logic signed [15:0] py,
                                              input logic signed [15:0] ny,
                                              input logic [15:0] delta);
      logic signed [17:0] dx;
      logic signed [17:0] dy;
      logic signed [17:0] d;
      logic [3:0]         f;
      dx   = 18'(nx) - 18'(px);
      dy   = 18'(ny) - 18'(py);
      d    = signed'({2'b00, delta});
      f[0] = (dx >= d)  && !px[15];
      f[1] = (dx <= -d) && (px[15] || (px == '0));
      f[2] = (dy >= d)  && !py[15];
      f[3] = (dy <= -d) && (py[15] || (py == '0));
      return f;
   endfunction

endpackage

>>> rtl/gpq_front.sv
// ----------------------------------------------------------------------------
// gpq_front
// Unpack a poll word, range-check player and report button, and push the
// classified item into the queue.
// ----------------------------------------------------------------------------
module gpq_front (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [gpq_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [gpq_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                          push,
   output gpq_pkg::item_type             push_item,
   input  logic                          queue_ready
);
   import gpq_pkg::*;

   logic [1:0] player;
   logic [3:0] report_btn;

   assign player     = req_tuser[1:0];
   assign report_btn = req_tdata[99:96];

   always_comb begin
      push_item.player_ok     = 32'(player) < 32'(PLAYERS);
      push_item.player_idx    = PLAYER_IDX_W'(player);
      push_item.poll_ok       = req_tuser[2];
      push_item.buttons       = req_tdata[15:0];
      push_item.left_trigger  = req_tdata[23:16];
      push_item.right_trigger = req_tdata[31:24];
      push_item.left_x        = req_tdata[47:32];
      push_item.left_y        = req_tdata[63:48];
      push_item.right_x       = req_tdata[79:64];
      push_item.right_y       = req_tdata[95:80];
      push_item.button_ok     = 32'(report_btn) < 32'(BUTTON_COUNT);
      push_item.button_idx    = BTN_IDX_W'(report_btn);
   end

   assign req_tready = queue_ready;
   assign push       = req_tvalid && queue_ready;

endmodule

>>> rtl/gpq_queue.sv
// ----------------------------------------------------------------------------
// gpq_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module gpq_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gpq_pkg::item_type push_item,
   output logic              push_ready,
   input  logic              pop,
   output gpq_pkg::item_type pop_item,
   output logic              pop_valid
);
   import gpq_pkg::*;

   item_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign push_ready = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/gpq_back.sv
// ----------------------------------------------------------------------------
// gpq_back
// Per-player state, hold counters, edge and flag update, result register and
// configuration registers.
// ----------------------------------------------------------------------------
module gpq_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_valid,
   input  gpq_pkg::item_type              item,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [gpq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [gpq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gpq_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gpq_pkg::*;

   logic [7:0]  threshold_ff, threshold_in;
   logic [15:0] flick_delta_ff, flick_delta_in;

   logic [15:0] prev_buttons_ff  [PLAYERS];
   logic [15:0] prev_buttons_in  [PLAYERS];
   logic [15:0] prev_triggers_ff [PLAYERS];
   logic [15:0] prev_triggers_in [PLAYERS];
   logic [63:0] prev_axes_ff     [PLAYERS];
   logic [63:0] prev_axes_in     [PLAYERS];
   logic [31:0] edge_masks_ff    [PLAYERS];
   logic [31:0] edge_masks_in    [PLAYERS];
   logic [11:0] analog_flags_ff  [PLAYERS];
   logic [11:0] analog_flags_in  [PLAYERS];
   count_type   hold_ff          [PLAYERS][BUTTON_COUNT];
   count_type   hold_in          [PLAYERS][BUTTON_COUNT];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [15:0] old_buttons;
   logic [15:0] old_triggers;
   logic [63:0] old_axes;
   count_type   cnt_row [BUTTON_COUNT];
   logic [15:0] new_buttons;
   logic [31:0] new_edges;
   logic [11:0] new_flags;
   logic [3:0]  trig_bits;
   logic [15:0] hold_report;

   assign pop        = item_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      threshold_in   = threshold_ff;
      flick_delta_in = flick_delta_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TRIGGER_THRESHOLD: threshold_in   = csr_wdata[7:0];
            CSR_FLICK_DELTA:       flick_delta_in = csr_wdata[15:0];
            default:               threshold_in   = threshold_ff;
         endcase
      end
   end

   always_comb begin
      old_buttons  = prev_buttons_ff[item.player_idx];
      old_triggers = prev_triggers_ff[item.player_idx];
      old_axes     = prev_axes_ff[item.player_idx];

      // counters follow the stored buttons, whatever the poll says
      for (int b = 0; b < BUTTON_COUNT; b++) begin
         if (old_buttons[b]) begin
            cnt_row[b] = (hold_ff[item.player_idx][b] == COUNT_MAX) ?
                         COUNT_MAX : hold_ff[item.player_idx][b] + 1'b1;
         end else begin
            cnt_row[b] = '0;
         end
      end

      trig_bits[0] = trigger_rise(item.right_trigger, old_triggers[7:0], threshold_ff);
      trig_bits[1] = trigger_rise(item.left_trigger, old_triggers[15:8], threshold_ff);
      trig_bits[2] = old_triggers[7:0] > threshold_ff;
      trig_bits[3] = old_triggers[15:8] > threshold_ff;

      if (item.poll_ok) begin
         new_buttons = item.buttons;
         new_edges   = {(old_buttons ^ item.buttons) & old_buttons,
                        (old_buttons ^ item.buttons) & item.buttons};
         new_flags   = {flick_flags(old_axes[47:32], item.right_x,
                                    old_axes[63:48], item.right_y, flick_delta_ff),
                        flick_flags(old_axes[15:0], item.left_x,
                                    old_axes[31:16], item.left_y, flick_delta_ff),
                        trig_bits};
      end else begin
         new_buttons = old_buttons;
         new_edges   = edge_masks_ff[item.player_idx];
         new_flags   = analog_flags_ff[item.player_idx];
      end

      hold_report = item.button_ok ? report_count(cnt_row[item.button_idx]) : '0;

      prev_buttons_in  = prev_buttons_ff;
      prev_triggers_in = prev_triggers_ff;
      prev_axes_in     = prev_axes_ff;
      edge_masks_in    = edge_masks_ff;
      analog_flags_in  = analog_flags_ff;
      hold_in          = hold_ff;
      if (pop && item.player_ok) begin
         hold_in[item.player_idx] = cnt_row;
         if (item.poll_ok) begin
            prev_buttons_in[item.player_idx]  = item.buttons;
            prev_triggers_in[item.player_idx] = {item.left_trigger, item.right_trigger};
            prev_axes_in[item.player_idx]     = {item.right_y, item.right_x,
                                                 item.left_y, item.left_x};
            edge_masks_in[item.player_idx]    = new_edges;
            analog_flags_in[item.player_idx]  = new_flags;
         end
      end

      // result word: pressed, press, release, hold count, flags from bit 0 up
      if (item.player_ok) begin
         rsp_data_in = {4'b0000, new_flags, hold_report, new_edges, new_buttons};
      end else begin
         rsp_data_in = '0;
      end

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= THRESHOLD_RESET;
         flick_delta_ff <= FLICK_RESET;
         rsp_valid_ff   <= 1'b0;
         for (int p = 0; p < PLAYERS; p++) begin
            prev_buttons_ff[p]  <= '0;
            prev_triggers_ff[p] <= '0;
            prev_axes_ff[p]     <= '0;
            edge_masks_ff[p]    <= '0;
            analog_flags_ff[p]  <= '0;
            for (int b = 0; b < BUTTON_COUNT; b++) begin
               hold_ff[p][b] <= '0;
            end
         end
      end else begin
         threshold_ff     <= threshold_in;
         flick_delta_ff   <= flick_delta_in;
         rsp_valid_ff     <= rsp_valid_in;
         prev_buttons_ff  <= prev_buttons_in;
         prev_triggers_ff <= prev_triggers_in;
         prev_axes_ff     <= prev_axes_in;
         edge_masks_ff    <= edge_masks_in;
         analog_flags_ff  <= analog_flags_in;
         hold_ff          <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> rtl/gamepad_input_qualifier_top.sv
// ----------------------------------------------------------------------------
// gamepad_input_qualifier_top
// Per-player button edge detector with hold counters, trigger and stick
// flick flags, one result word for every poll word.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req_     in         req_tvalid/req_tready  req_tdata 104b, req_tuser 3b
//   rsp_     out        rsp_tvalid/rsp_tready  rsp_tdata 80b
//   csr_     in         csr_we (no wait)       csr_index 1b, csr_wdata 16b
//
// One poll word per cycle is sustained while rsp_tready stays high; an
// accepted word is first written into the queue, then the back pops it and
// moves its state update into the result register behind rsp_tvalid. The
// per-player state is read and written when the back pops a word, so
// consecutive polls of the same player see each other's update.
// A two-word queue between front and back absorbs up to two words while a
// result waits on rsp_tready; after that req_tready drops until the back pops
// again. Reset is synchronous: it clears all player state, sets the registers
// to their defaults and empties the queue.
//
module gamepad_input_qualifier_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // buttons, left_trigger, right_trigger, left_x, left_y, right_x, right_y,
   // report_button, zero pad
   input  logic [gpq_pkg::REQ_DATA_W-1:0] req_tdata,
   // player, poll_ok
   input  logic [gpq_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // pressed_mask, press_edges, release_edges, hold_count, trigger_edges,
   // trigger_presses, left_flicks, right_flicks, zero pad
   output logic [gpq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [gpq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gpq_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gpq_pkg::*;

   logic     push;
   logic     push_ready;
   item_type push_item;
   logic     pop;
   logic     pop_valid;
   item_type pop_item;

   // classify the poll word and push it
   gpq_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .push        (push),
      .push_item   (push_item),
      .queue_ready (push_ready)
   );

   // hold classified words until the back is free
   gpq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_item   (pop_item),
      .pop_valid  (pop_valid)
   );

   // advance player state and register the result word
   gpq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item       (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

>>> rtl/gpq_checker.sv
// ----------------------------------------------------------------------------
// gpq_checker
// Port-level checks of the result channel of the gamepad input qualifier.
// ----------------------------------------------------------------------------
module gpq_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [gpq_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import gpq_pkg::*;

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a press edge is a button that is down now
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31:16] & ~rsp_tdata[15:0]) == 16'h0000)
      else $error("press edge on a released button");

   // a release edge is a button that is up now
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[47:32] & rsp_tdata[15:0]) == 16'h0000)
      else $error("release edge on a pressed button");

endmodule

bind gamepad_input_qualifier_top gpq_checker u_gpq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
